FILE: src/gfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and lookup functions for the NMEA GGA/RMC parser.
package gfp_pkg;

  localparam int MFD_DEFAULT = 4;
  localparam int FRAC_W      = 17;
  localparam int INT_W       = 20;
  localparam int FIELD_W     = 5;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [INT_W-1:0] INT_MAX = 20'hFFFFF;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] KIND_NONE = 2'b00;
  localparam logic [1:0] KIND_GGA  = 2'b01;
  localparam logic [1:0] KIND_RMC  = 2'b10;
  localparam logic [1:0] KIND_BOTH = 2'b11;

  localparam logic [FIELD_W-1:0] F_LAT    = 5'd2;
  localparam logic [FIELD_W-1:0] F_LATH   = 5'd3;
  localparam logic [FIELD_W-1:0] F_LON    = 5'd4;
  localparam logic [FIELD_W-1:0] F_LONH   = 5'd5;
  localparam logic [FIELD_W-1:0] F_FIX    = 5'd6;
  localparam logic [FIELD_W-1:0] F_SAT    = 5'd7;
  localparam logic [FIELD_W-1:0] F_COURSE = 5'd8;
  localparam logic [FIELD_W-1:0] F_ALT    = 5'd9;
  localparam logic [FIELD_W-1:0] F_MAX    = 5'd31;

  // field event from parser front to arithmetic back
  typedef struct packed {
    logic               clr;
    logic               commit;
    logic               emit;
    logic               rmc;
    logic [FIELD_W-1:0] field;
    logic [INT_W-1:0]   int_v;
    logic [FRAC_W-1:0]  frac;
    logic [2:0]         fdig;
    logic               neg;
    logic               hemi_ok;
    logic [7:0]         hemi;
  } gfp_ev_t;

  function automatic logic [7:0] hdr_gga(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h47;
      3'd1:    return 8'h50;
      3'd2:    return 8'h47;
      3'd3:    return 8'h47;
      3'd4:    return 8'h41;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] hdr_rmc(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h47;
      3'd1:    return 8'h50;
      3'd2:    return 8'h52;
      3'd3:    return 8'h4D;
      3'd4:    return 8'h43;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(input logic [2:0] n);
    case (n)
      3'd0:    return 17'd1;
      3'd1:    return 17'd10;
      3'd2:    return 17'd100;
      3'd3:    return 17'd1000;
      3'd4:    return 17'd10000;
      3'd5:    return 17'd100000;
      default: return 17'd1;
    endcase
  endfunction

  // fractional digits kept for a field
  function automatic logic [2:0] frac_lim(input logic rmc, input logic [FIELD_W-1:0] field,
                                          input logic [2:0] mfd);
    if (rmc) return (field == F_COURSE) ? 3'd2 : 3'd0;
    if (field == F_LAT || field == F_LON) return mfd;
    if (field == F_ALT) return 3'd1;
    return 3'd0;
  endfunction

endpackage

FILE: src/gfp_fifo.sv
`timescale 1ns / 1ps
// Small register FIFO between parser front and arithmetic back.
module gfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output logic [WIDTH-1:0] rdata
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign avail = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end
endmodule

FILE: src/gfp_front.sv
`timescale 1ns / 1ps
// Character parser: header match, field counting and digit accumulation.
module gfp_front
  import gfp_pkg::*;
#(
  parameter int MINUTE_FRAC_DIGITS = MFD_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] ch,
  output logic       ev_push,
  output gfp_ev_t    ev
);
  localparam logic [2:0] MFD = 3'(MINUTE_FRAC_DIGITS);

  logic               ins_r, ins_nxt;
  logic [2:0]         hp_r, hp_nxt;
  logic [1:0]         kf_r, kf_nxt;
  logic [FIELD_W-1:0] fi_r, fi_nxt;
  logic [3:0]         cif_r, cif_nxt;
  logic [INT_W-1:0]   int_r, int_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [2:0]         fd_r, fd_nxt;
  logic               neg_r, neg_nxt;
  logic               pt_r, pt_nxt;
  logic [7:0]         fc_r, fc_nxt;

  logic               rmc;
  logic [3:0]         dig;
  logic [23:0]        iv;
  logic [1:0]         kf_t;

  assign rmc = (kf_r == KIND_RMC);
  assign dig = 4'(ch - CH_ZERO);
  assign iv  = 24'(int_r) * 24'd10 + 24'(dig);

  always_comb begin
    ins_nxt  = ins_r;
    hp_nxt   = hp_r;
    kf_nxt   = kf_r;
    fi_nxt   = fi_r;
    cif_nxt  = cif_r;
    int_nxt  = int_r;
    frac_nxt = frac_r;
    fd_nxt   = fd_r;
    neg_nxt  = neg_r;
    pt_nxt   = pt_r;
    fc_nxt   = fc_r;
    kf_t     = kf_r;
    ev.clr     = 1'b0;
    ev.commit  = 1'b0;
    ev.emit    = 1'b0;
    ev.rmc     = rmc;
    ev.field   = fi_r;
    ev.int_v   = int_r;
    ev.frac    = frac_r;
    ev.fdig    = fd_r;
    ev.neg     = neg_r;
    ev.hemi_ok = (cif_r != '0);
    ev.hemi    = fc_r;
    if (acc) begin
      if (ch == CH_DOLLAR) begin
        ev.clr  = 1'b1;
        ins_nxt = 1'b1;
        hp_nxt  = '0;
        kf_nxt  = KIND_BOTH;
        fi_nxt  = '0;
        cif_nxt = '0; int_nxt = '0; frac_nxt = '0; fd_nxt = '0; neg_nxt = 1'b0; pt_nxt = 1'b0;
      end else if (ins_r) begin
        if (ch == CH_STAR || ch == CH_CR || ch == CH_LF) begin
          ins_nxt = 1'b0;
          if (fi_r != '0) begin
            ev.commit = 1'b1;
            ev.emit   = 1'b1;
          end
        end else if (fi_r == '0) begin
          if (ch == CH_COMMA) begin
            if (hp_r == 3'd5 && (kf_r == KIND_GGA || kf_r == KIND_RMC)) begin
              fi_nxt  = 5'd1;
              cif_nxt = '0; int_nxt = '0; frac_nxt = '0; fd_nxt = '0;
              neg_nxt = 1'b0; pt_nxt = 1'b0;
            end else begin
              ins_nxt = 1'b0;
            end
          end else if (hp_r >= 3'd5) begin
            ins_nxt = 1'b0;
          end else begin
            if (ch != hdr_gga(hp_r)) kf_t[0] = 1'b0;
            if (ch != hdr_rmc(hp_r)) kf_t[1] = 1'b0;
            kf_nxt = kf_t;
            hp_nxt = hp_r + 3'd1;
            if (kf_t == KIND_NONE) ins_nxt = 1'b0;
          end
        end else if (ch == CH_COMMA) begin
          ev.commit = 1'b1;
          if (fi_r != F_MAX) fi_nxt = fi_r + 5'd1;
          cif_nxt = '0; int_nxt = '0; frac_nxt = '0; fd_nxt = '0; neg_nxt = 1'b0; pt_nxt = 1'b0;
        end else begin
          if (cif_r == '0) fc_nxt = ch;
          if (ch == CH_MINUS && cif_r == '0) begin
            neg_nxt = 1'b1;
          end else if (ch == CH_DOT) begin
            pt_nxt = 1'b1;
          end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (!pt_r) begin
              int_nxt = (int_r > INT_W'(INT_MAX / 10) || iv > 24'(INT_MAX)) ? INT_MAX
                                                                              : iv[INT_W-1:0];
            end else if (fd_r < frac_lim(rmc, fi_r, MFD)) begin
              frac_nxt = FRAC_W'(frac_r * FRAC_W'(10)) + FRAC_W'(dig);
              fd_nxt   = fd_r + 3'd1;
            end
          end
          if (cif_r != 4'd15) cif_nxt = cif_r + 4'd1;
        end
      end
    end
  end

  assign ev_push = ev.clr | ev.commit | ev.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r  <= 1'b0;
      hp_r   <= '0;
      kf_r   <= KIND_NONE;
      fi_r   <= '0;
      cif_r  <= '0;
      int_r  <= '0;
      frac_r <= '0;
      fd_r   <= '0;
      neg_r  <= 1'b0;
      pt_r   <= 1'b0;
      fc_r   <= CH_SPACE;
    end else begin
      ins_r  <= ins_nxt;
      hp_r   <= hp_nxt;
      kf_r   <= kf_nxt;
      fi_r   <= fi_nxt;
      cif_r  <= cif_nxt;
      int_r  <= int_nxt;
      frac_r <= frac_nxt;
      fd_r   <= fd_nxt;
      neg_r  <= neg_nxt;
      pt_r   <= pt_nxt;
      fc_r   <= fc_nxt;
    end
  end
endmodule

FILE: src/gfp_back.sv
`timescale 1ns / 1ps
// Field conversion pipeline, result holds and output register.
module gfp_back
  import gfp_pkg::*;
#(
  parameter int MINUTE_FRAC_DIGITS = MFD_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ev_avail,
  input  gfp_ev_t       ev,
  output logic          ev_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,
  output logic          out_tuser
);
  localparam logic [2:0]  MFD    = 3'(MINUTE_FRAC_DIGITS);
  localparam logic [23:0] SCALE  = 24'(10 ** MINUTE_FRAC_DIGITS);
  localparam logic [29:0] SCALE7 = 30'(10 ** (7 - MINUTE_FRAC_DIGITS));
  localparam logic [19:0] M25    = 20'd671089;     // ceil(2^24/25)
  localparam logic [28:0] M15    = 29'd286331154;  // ceil(2^32/15)
  localparam logic [32:0] LAT_MAX = 33'd900000000;
  localparam logic [32:0] LON_MAX = 33'd1800000000;

  logic en;

  // stage 1
  logic          v1_r;
  gfp_ev_t       e1_r;
  logic [37:0]   q1_r;
  logic [FRAC_W-1:0] fs1_r;
  // stage 2
  logic          v2_r;
  gfp_ev_t       e2_r;
  logic [7:0]    deg2_r;
  logic          big2_r;
  logic [23:0]   min2_r;
  logic [3:0]    fix2_r;
  logic [6:0]    sat2_r;
  logic [20:0]   alt2_r;
  logic [15:0]   crs2_r;
  // stage 3
  logic          v3_r;
  gfp_ev_t       e3_r;
  logic          big3_r;
  logic [29:0]   x3_r;
  logic [31:0]   d7_3_r;
  logic [3:0]    fix3_r;
  logic [6:0]    sat3_r;
  logic [20:0]   alt3_r;
  logic [15:0]   crs3_r;
  // stage 4
  logic          v4_r;
  gfp_ev_t       e4_r;
  logic          big4_r;
  logic [56:0]   p4_r;
  logic [31:0]   d7_4_r;
  logic [3:0]    fix4_r;
  logic [6:0]    sat4_r;
  logic [20:0]   alt4_r;
  logic [15:0]   crs4_r;

  // holds
  logic [29:0] lat_r, lat_nxt;
  logic [30:0] lon_r, lon_nxt;
  logic [7:0]  lath_r, lath_nxt, lonh_r, lonh_nxt;
  logic [3:0]  fix_r, fix_nxt;
  logic [6:0]  sat_r, sat_nxt;
  logic [20:0] alt_r, alt_nxt;
  logic [15:0] crs_r, crs_nxt;
  logic        ov_r;

  logic [FRAC_W-1:0] fs_c;
  logic [13:0]       deg_c;
  logic [19:0]       mm_full;
  logic [23:0]       altv_c;
  logic [26:0]       crsv_c;
  logic [32:0]       sum_c, lat_c, lon_c;

  assign en     = !(ov_r && !out_tready);
  assign ev_pop = en && ev_avail;

  assign fs_c = FRAC_W'(ev.frac * pow10(frac_lim(ev.rmc, ev.field, MFD) - ev.fdig));

  assign deg_c   = q1_r[37:24];
  assign mm_full = e1_r.int_v - 20'(deg_c * 14'd100);
  assign altv_c  = 24'(e1_r.int_v) * 24'd10 + 24'(fs1_r);
  assign crsv_c  = 27'(e1_r.int_v) * 27'd100 + 27'(fs1_r);

  assign sum_c = 33'(d7_4_r) + 33'(p4_r[56:32]);
  assign lat_c = (big4_r || sum_c > LAT_MAX) ? LAT_MAX : sum_c;
  assign lon_c = (big4_r || sum_c > LON_MAX) ? LON_MAX : sum_c;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r   <= ev;
      q1_r   <= 38'(ev.int_v[19:2]) * 38'(M25);
      fs1_r  <= fs_c;

      e2_r   <= e1_r;
      deg2_r <= deg_c[7:0];
      big2_r <= (deg_c > 14'd255);
      min2_r <= 24'(mm_full[6:0]) * SCALE + 24'(fs1_r);
      fix2_r <= (e1_r.int_v > 20'd9) ? 4'd9 : e1_r.int_v[3:0];
      sat2_r <= (e1_r.int_v > 20'd99) ? 7'd99 : e1_r.int_v[6:0];
      if (e1_r.neg) alt2_r <= (altv_c > 24'd99999) ? -21'sd99999 : 21'(-altv_c);
      else          alt2_r <= (altv_c > 24'd999999) ? 21'd999999 : altv_c[20:0];
      crs2_r <= (crsv_c > 27'd36000) ? 16'd36000 : crsv_c[15:0];

      e3_r   <= e2_r;
      big3_r <= big2_r;
      x3_r   <= 30'(min2_r) * SCALE7;
      d7_3_r <= 32'(deg2_r) * 32'd10000000;
      fix3_r <= fix2_r; sat3_r <= sat2_r; alt3_r <= alt2_r; crs3_r <= crs2_r;

      e4_r   <= e3_r;
      big4_r <= big3_r;
      p4_r   <= 57'(x3_r[29:2]) * 57'(M15);
      d7_4_r <= d7_3_r;
      fix4_r <= fix3_r; sat4_r <= sat3_r; alt4_r <= alt3_r; crs4_r <= crs3_r;
    end
  end

  always_comb begin
    lat_nxt  = lat_r;
    lon_nxt  = lon_r;
    lath_nxt = lath_r;
    lonh_nxt = lonh_r;
    fix_nxt  = fix_r;
    sat_nxt  = sat_r;
    alt_nxt  = alt_r;
    crs_nxt  = crs_r;
    if (v4_r) begin
      if (e4_r.clr) begin
        lat_nxt = '0; lon_nxt = '0; lath_nxt = CH_SPACE; lonh_nxt = CH_SPACE;
        fix_nxt = '0; sat_nxt = '0; alt_nxt = '0; crs_nxt = '0;
      end else if (e4_r.commit) begin
        if (e4_r.rmc) begin
          if (e4_r.field == F_COURSE) crs_nxt = crs4_r;
        end else begin
          case (e4_r.field)
            F_LAT:   lat_nxt = lat_c[29:0];
            F_LATH:  if (e4_r.hemi_ok) lath_nxt = e4_r.hemi;
            F_LON:   lon_nxt = lon_c[30:0];
            F_LONH:  if (e4_r.hemi_ok) lonh_nxt = e4_r.hemi;
            F_FIX:   fix_nxt = fix4_r;
            F_SAT:   sat_nxt = sat4_r;
            F_ALT:   alt_nxt = alt4_r;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      ov_r <= 1'b0;
      lat_r <= '0; lon_r <= '0; lath_r <= CH_SPACE; lonh_r <= CH_SPACE;
      fix_r <= '0; sat_r <= '0; alt_r <= '0; crs_r <= '0;
    end else begin
      if (en) begin
        v1_r <= ev_pop;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        lat_r <= lat_nxt; lon_r <= lon_nxt; lath_r <= lath_nxt; lonh_r <= lonh_nxt;
        fix_r <= fix_nxt; sat_r <= sat_nxt; alt_r <= alt_nxt; crs_r <= crs_nxt;
        ov_r <= v4_r && e4_r.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v4_r && e4_r.emit) begin
      out_tuser <= e4_r.rmc;
      out_tdata <= {3'b000, crs_nxt, alt_nxt, sat_nxt, fix_nxt, lonh_nxt, lon_nxt,
                    lath_nxt, lat_nxt};
    end
  end

  assign out_tvalid = ov_r;
endmodule

FILE: src/nmea_gga_rmc_field_parser.sv
`timescale 1ns / 1ps
// NMEA 0183 GGA/RMC field parser: one character per cycle, one result per sentence.
// Throughput: one character accepted every cycle; a request waits only when the event
// FIFO fills behind a stalled result. The terminating character's event passes through the event
// FIFO, the 4-stage conversion pipeline and the output register before out_tvalid rises.
// Reset (rst_n low, synchronous) clears parser state, holds and the output valid.
module nmea_gga_rmc_field_parser
  import gfp_pkg::*;
#(
  parameter int MINUTE_FRAC_DIGITS = MFD_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // char_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // lat_e7, lat_hemi, lon_e7, lon_hemi, fix_quality,
                                   // sat_count, alt_dm, course_cdeg, zero pad
  output logic         out_tuser   // sentence_kind
);
  localparam int EV_W = $bits(gfp_ev_t);

  logic    full, avail, push, pop;
  gfp_ev_t ev_w, ev_r;
  logic [EV_W-1:0] rd;

  assign in_tready = !full;
  assign ev_r      = gfp_ev_t'(rd);

  gfp_front #(.MINUTE_FRAC_DIGITS(MINUTE_FRAC_DIGITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_tvalid && in_tready),
    .ch      (in_tdata),
    .ev_push (push),
    .ev      (ev_w)
  );

  gfp_fifo #(.WIDTH(EV_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (ev_w),
    .full  (full),
    .pop   (pop),
    .avail (avail),
    .rdata (rd)
  );

  gfp_back #(.MINUTE_FRAC_DIGITS(MINUTE_FRAC_DIGITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_avail   (avail),
    .ev         (ev_r),
    .ev_pop     (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule
